>>> rtl/btu_pkg.sv
// btu_pkg: shared types and constants for the baud tick uart transceiver
// no dependencies; imported by every module under rtl/
package btu_pkg;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_WRITE_TX  = 3'd1,
        ACT_POP_RX    = 3'd2,
        ACT_CLR_READY = 3'd3,
        ACT_CLR_IRQ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_DATA  = 2'd1,
        PH_STOP  = 2'd2,
        PH_EOF   = 2'd3
    } phase_t;

    localparam logic [2:0] REG_BAUD_DIVISOR  = 3'd0;
    localparam logic [2:0] REG_EIGHT_BIT     = 3'd1;
    localparam logic [2:0] REG_BLOCK_ENABLE  = 3'd2;
    localparam logic [2:0] REG_TX_ENABLE     = 3'd3;
    localparam logic [2:0] REG_RX_ENABLE     = 3'd4;
    localparam logic [2:0] REG_RX_IRQ_ENABLE = 3'd5;
    localparam logic [2:0] REG_TX_IRQ_ENABLE = 3'd6;

    localparam logic [3:0] CHAR_BITS_7 = 4'd7;
    localparam logic [3:0] CHAR_BITS_8 = 4'd8;

    typedef struct packed {
        logic [15:0] baud_divisor;
        logic        eight_bit_chars;
        logic        block_enable;
        logic        tx_enable;
        logic        rx_enable;
        logic        rx_irq_enable;
        logic        tx_irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] cycles;
        logic        rx_level;
        logic [7:0]  tx_byte;
    } in_item_t;

    typedef struct packed {
        logic step;
        logic load;
    } tx_ctrl_t;

    typedef struct packed {
        logic commit;
        logic step;
        logic pop;
        logic clear_ready;
    } rx_ctrl_t;

    typedef struct packed {
        logic [7:0] popped_byte;
        logic       popped_valid;
        logic [7:0] io_byte;
        logic       ready;
        logic       stop_error;
        logic       overflow;
    } rx_stat_t;

    function automatic logic [3:0] char_bits(input logic eight_bit);
        return eight_bit ? CHAR_BITS_8 : CHAR_BITS_7;
    endfunction

endpackage

>>> rtl/btu_baud.sv
// btu_baud: cycle accumulator that fires one bit period when the divisor is reached
// depends on btu_pkg
module btu_baud (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic [15:0] cycles,
    input  logic [15:0] baud_divisor,
    output logic        bit_period
);
    import btu_pkg::*;

    logic [16:0] accum_reg;
    logic [16:0] accum_next;
    logic [16:0] sum;
    logic        hit;

    always_comb
    begin
        sum        = accum_reg + {1'b0, cycles};
        hit        = (sum >= {1'b0, baud_divisor});
        accum_next = accum_reg;
        if (tick)
        begin
            accum_next = hit ? '0 : sum;
        end
        bit_period = tick && hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
        end
    end

endmodule

>>> rtl/btu_tx.sv
// btu_tx: transmit shift register and frame sequencer, one step per bit period
// depends on btu_pkg
module btu_tx (
    input  logic            clk,
    input  logic            rst_n,
    input  btu_pkg::tx_ctrl_t ctrl,
    input  logic [7:0]      tx_byte,
    input  btu_pkg::cfg_t   cfg,
    output logic            tx_line,
    output logic            tx_empty,
    output logic            irq_raise
);
    import btu_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] bits_reg;
    logic [3:0] bits_next;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic       line_reg;
    logic       line_next;
    logic       empty_reg;
    logic       empty_next;

    always_comb
    begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        empty_next = empty_reg;
        irq_raise  = 1'b0;
        if (ctrl.load)
        begin
            shift_next = tx_byte;
            empty_next = 1'b0;
        end
        else if (ctrl.step && !empty_reg && cfg.tx_enable)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    line_next  = 1'b0;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    line_next  = shift_reg[0];
                    shift_next = {1'b0, shift_reg[7:1]};
                    bits_next  = bits_reg + 4'd1;
                    if (bits_next >= char_bits(cfg.eight_bit_chars))
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    line_next  = 1'b1;
                    phase_next = PH_EOF;
                end
                PH_EOF:
                begin
                    phase_next = PH_START;
                    bits_next  = '0;
                    empty_next = 1'b1;
                    irq_raise  = cfg.tx_irq_enable;
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            bits_reg  <= '0;
            shift_reg <= '0;
            line_reg  <= 1'b1;
            empty_reg <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            line_reg  <= line_next;
            empty_reg <= empty_next;
        end
    end

    assign tx_line  = line_reg;
    assign tx_empty = empty_reg;

endmodule

>>> rtl/btu_rx.sv
// btu_rx: receive sequencer, receive fifo and received byte flags
// depends on btu_pkg
module btu_rx #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  btu_pkg::rx_ctrl_t          ctrl,
    input  logic                       rx_level,
    input  btu_pkg::cfg_t              cfg,
    output btu_pkg::rx_stat_t          stat,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       irq_raise
);
    import btu_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       mem [DEPTH];

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [3:0]       bits_reg;
    logic [3:0]       bits_next;
    logic [7:0]       shift_reg;
    logic [7:0]       shift_next;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       io_byte_reg;
    logic [7:0]       io_byte_next;
    logic             ready_reg;
    logic             ready_next;
    logic             stop_err_reg;
    logic             stop_err_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             popped_valid_reg;
    logic [7:0]       popped_byte_reg;
    logic             push;
    logic             pop_ok;

    always_comb
    begin
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        io_byte_next  = io_byte_reg;
        ready_next    = ready_reg;
        stop_err_next = 1'b0;
        overflow_next = 1'b0;
        push          = 1'b0;
        pop_ok        = 1'b0;
        irq_raise     = 1'b0;
        if (ctrl.step && cfg.rx_enable)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (!rx_level)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (!bits_reg[3])
                    begin
                        shift_next[bits_reg[2:0]] = shift_reg[bits_reg[2:0]] | rx_level;
                    end
                    bits_next = bits_reg + 4'd1;
                    if (bits_next >= char_bits(cfg.eight_bit_chars))
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    stop_err_next = !rx_level;
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        push       = 1'b1;
                        tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    io_byte_next = shift_reg;
                    ready_next   = 1'b1;
                    phase_next   = PH_START;
                    bits_next    = '0;
                    shift_next   = '0;
                    irq_raise    = cfg.rx_irq_enable;
                end
                PH_EOF:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
        if (ctrl.pop && (count_reg != '0))
        begin
            pop_ok     = 1'b1;
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctrl.clear_ready)
        begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            bits_reg         <= '0;
            shift_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            io_byte_reg      <= '0;
            ready_reg        <= 1'b0;
            stop_err_reg     <= 1'b0;
            overflow_reg     <= 1'b0;
            popped_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            phase_reg        <= phase_next;
            bits_reg         <= bits_next;
            shift_reg        <= shift_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            io_byte_reg      <= io_byte_next;
            ready_reg        <= ready_next;
            stop_err_reg     <= stop_err_next;
            overflow_reg     <= overflow_next;
            popped_valid_reg <= pop_ok;
        end
    end

    // fifo storage, read data lands straight in the result field
    always_ff @(posedge clk)
    begin
        if (ctrl.commit && push)
        begin
            mem[tail_reg] <= shift_reg;
        end
        if (ctrl.commit)
        begin
            popped_byte_reg <= pop_ok ? mem[head_reg] : '0;
        end
    end

    always_comb
    begin
        stat.popped_byte  = popped_valid_reg ? popped_byte_reg : '0;
        stat.popped_valid = popped_valid_reg;
        stat.io_byte      = io_byte_reg;
        stat.ready        = ready_reg;
        stat.stop_error   = stop_err_reg;
        stat.overflow     = overflow_reg;
    end

    assign count = count_reg;

endmodule

>>> rtl/baud_tick_uart_transceiver_unit.sv
// baud_tick_uart_transceiver_unit: top level with input register, config registers,
// irq flags and result register; uses btu_pkg, btu_baud, btu_tx, btu_rx
//
//  channel  | signals                         | transfer when
//  ---------+---------------------------------+------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | s_tvalid && s_tready
//  result   | m_tvalid m_tready m_tdata       | m_tvalid && m_tready
//  config   | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid && cfg_ready
//
// one item per cycle sustained while m_tready is high; an item waits in the input
// register until it advances, which updates the result register and raises m_tvalid
// the transmitter, receiver and fifo state is the result register, updated once per item
// s_tready drops only while both registers hold an item and m_tready is low
// reset clears all but input item, popped byte and fifo storage; cfg_ready stays high
module baud_tick_uart_transceiver_unit #(
    parameter int RX_FIFO_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // cycles[15:0], rx_level[16], tx_byte[24:17], zero
    input  logic [2:0]  s_tuser,    // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_level[0], popped_byte[8:1], popped_valid[9], last_received[17:10],
    // rx_ready[18], tx_empty[19], irq_pending[20], irq_is_receive[21],
    // irq_is_transmit[22], rx_count[26:23], stop_error[27], rx_overflow[28], zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import btu_pkg::*;

    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    in_item_t         in_item_reg;
    in_item_t         in_item_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             irq_pend_reg;
    logic             irq_pend_next;
    logic             irq_rx_reg;
    logic             irq_rx_next;
    logic             irq_tx_reg;
    logic             irq_tx_next;
    logic             advance;
    logic             bit_period;
    logic             tx_line;
    logic             tx_empty;
    logic             tx_irq;
    logic             rx_irq;
    tx_ctrl_t         tx_ctrl;
    rx_ctrl_t         rx_ctrl;
    rx_stat_t         rx_stat;
    logic [CNT_W-1:0] rx_count_full;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BAUD_DIVISOR:  cfg_next.baud_divisor    = cfg_data;
                REG_EIGHT_BIT:     cfg_next.eight_bit_chars = cfg_data[0];
                REG_BLOCK_ENABLE:  cfg_next.block_enable    = cfg_data[0];
                REG_TX_ENABLE:     cfg_next.tx_enable       = cfg_data[0];
                REG_RX_ENABLE:     cfg_next.rx_enable       = cfg_data[0];
                REG_RX_IRQ_ENABLE: cfg_next.rx_irq_enable   = cfg_data[0];
                REG_TX_IRQ_ENABLE: cfg_next.tx_irq_enable   = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next         = 1'b1;
            in_item_next.action   = s_tuser;
            in_item_next.cycles   = s_tdata[15:0];
            in_item_next.rx_level = s_tdata[16];
            in_item_next.tx_byte  = s_tdata[24:17];
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // action decode
    always_comb
    begin
        tx_ctrl.step        = advance && bit_period && cfg_reg.block_enable;
        tx_ctrl.load        = advance && (in_item_reg.action == ACT_WRITE_TX);
        rx_ctrl.commit      = advance;
        rx_ctrl.step        = advance && bit_period && cfg_reg.block_enable;
        rx_ctrl.pop         = advance && (in_item_reg.action == ACT_POP_RX);
        rx_ctrl.clear_ready = advance && (in_item_reg.action == ACT_CLR_READY);
    end

    always_comb
    begin
        irq_pend_next = irq_pend_reg;
        irq_rx_next   = irq_rx_reg;
        irq_tx_next   = irq_tx_reg;
        priority if (rx_irq)
        begin
            irq_pend_next = 1'b1;
            irq_rx_next   = 1'b1;
            irq_tx_next   = 1'b0;
        end
        else if (tx_irq)
        begin
            irq_pend_next = 1'b1;
            irq_rx_next   = 1'b0;
            irq_tx_next   = 1'b1;
        end
        else if (advance && (in_item_reg.action == ACT_CLR_IRQ))
        begin
            irq_pend_next = 1'b0;
            irq_rx_next   = 1'b0;
            irq_tx_next   = 1'b0;
        end
        else
        begin
            irq_pend_next = irq_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            irq_pend_reg  <= 1'b0;
            irq_rx_reg    <= 1'b0;
            irq_tx_reg    <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            irq_pend_reg  <= irq_pend_next;
            irq_rx_reg    <= irq_rx_next;
            irq_tx_reg    <= irq_tx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    btu_baud u_baud (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (advance && (in_item_reg.action == ACT_TICK)),
        .cycles       (in_item_reg.cycles),
        .baud_divisor (cfg_reg.baud_divisor),
        .bit_period   (bit_period)
    );

    btu_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tx_ctrl),
        .tx_byte   (in_item_reg.tx_byte),
        .cfg       (cfg_reg),
        .tx_line   (tx_line),
        .tx_empty  (tx_empty),
        .irq_raise (tx_irq)
    );

    btu_rx #(
        .DEPTH (RX_FIFO_DEPTH)
    ) u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .rx_level  (in_item_reg.rx_level),
        .cfg       (cfg_reg),
        .stat      (rx_stat),
        .count     (rx_count_full),
        .irq_raise (rx_irq)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        3'b000,
        rx_stat.overflow,
        rx_stat.stop_error,
        4'(rx_count_full),
        irq_tx_reg,
        irq_rx_reg,
        irq_pend_reg,
        tx_empty,
        rx_stat.ready,
        rx_stat.io_byte,
        rx_stat.popped_valid,
        rx_stat.popped_byte,
        tx_line
    };

    a_irq_type_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((irq_rx_reg || irq_tx_reg) == irq_pend_reg) && !(irq_rx_reg && irq_tx_reg))
        else $error("irq type flags disagree with pending flag");

    a_overflow_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stat.overflow |-> (rx_count_full == CNT_W'(RX_FIFO_DEPTH)))
        else $error("overflow reported with room in the fifo");

    a_input_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending input item lost while stalled");

endmodule

>>> tb/baud_tick_uart_transceiver_unit_tb.sv
// baud_tick_uart_transceiver_unit_tb: self-checking testbench for the baud tick uart
// transceiver; drives ticks, tx writes, pops and clears, predicts every status word
// depends on btu_pkg and baud_tick_uart_transceiver_unit
`timescale 1ns / 100ps

module baud_tick_uart_transceiver_unit_tb;
    import btu_pkg::*;

    localparam int RX_DEPTH = 8;
    localparam int ACT_CODE_MAX = 7;
    localparam int ITEM_TARGET = 1050;
    localparam int unsigned LIMIT_CYCLES = 1000000;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic       rx_overflow;
        logic       stop_error;
        logic [3:0] rx_count;
        logic       irq_is_transmit;
        logic       irq_is_receive;
        logic       irq_pending;
        logic       tx_empty;
        logic       rx_ready;
        logic [7:0] last_received;
        logic       popped_valid;
        logic [7:0] popped_byte;
        logic       tx_level;
    } uart_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // cycles[15:0], rx_level[16], tx_byte[24:17], zero
    logic [2:0]  s_tuser = '0;     // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // see uart_status_t, tx_level in bit 0
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [15:0] m_divisor;
    logic        m_eight, m_block, m_txen, m_rxen, m_rxirq, m_txirq;
    logic [16:0] accum;
    phase_t      tx_ph, rx_ph;
    logic [3:0]  tx_nbits, rx_nbits;
    logic [7:0]  tx_sreg, rx_sreg, io_last;
    logic        tx_line_q, tx_empty_q, ready_q, irq_pend_q, irq_rx_q, irq_tx_q;
    logic [7:0]  rx_fifo[$];

    uart_status_t expected_status[$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  items_sent = 0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_left = 0;
    int unsigned  pop_pct = 30;
    bit           no_idle = 1'b0;

    baud_tick_uart_transceiver_unit #(.RX_FIFO_DEPTH(RX_DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // result side backpressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle)
                stall_left = idle_len();
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("result %0d: %s expected %0h got %0h", results_seen, what, want, got);
        mismatches++;
    endtask

    task automatic compare_status(input uart_status_t want, input uart_status_t got);
        if (got.tx_level !== want.tx_level)
            report_mismatch("tx_level", want.tx_level, got.tx_level);
        if (got.popped_byte !== want.popped_byte)
            report_mismatch("popped_byte", want.popped_byte, got.popped_byte);
        if (got.popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", want.popped_valid, got.popped_valid);
        if (got.last_received !== want.last_received)
            report_mismatch("last_received", want.last_received, got.last_received);
        if (got.rx_ready !== want.rx_ready)
            report_mismatch("rx_ready", want.rx_ready, got.rx_ready);
        if (got.tx_empty !== want.tx_empty)
            report_mismatch("tx_empty", want.tx_empty, got.tx_empty);
        if (got.irq_pending !== want.irq_pending)
            report_mismatch("irq_pending", want.irq_pending, got.irq_pending);
        if (got.irq_is_receive !== want.irq_is_receive)
            report_mismatch("irq_is_receive", want.irq_is_receive, got.irq_is_receive);
        if (got.irq_is_transmit !== want.irq_is_transmit)
            report_mismatch("irq_is_transmit", want.irq_is_transmit, got.irq_is_transmit);
        if (got.rx_count !== want.rx_count)
            report_mismatch("rx_count", want.rx_count, got.rx_count);
        if (got.stop_error !== want.stop_error)
            report_mismatch("stop_error", want.stop_error, got.stop_error);
        if (got.rx_overflow !== want.rx_overflow)
            report_mismatch("rx_overflow", want.rx_overflow, got.rx_overflow);
        if (got.pad !== want.pad)
            report_mismatch("padding", want.pad, got.pad);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_status.size() == 0)
                report_mismatch("unexpected result", '0, m_tdata);
            else
                compare_status(expected_status.pop_front(), uart_status_t'(m_tdata));
        end
    end

    function automatic void reset_model();
        m_divisor = '0;
        m_eight = 1'b0;
        m_block = 1'b0;
        m_txen = 1'b0;
        m_rxen = 1'b0;
        m_rxirq = 1'b0;
        m_txirq = 1'b0;
        accum = '0;
        tx_ph = PH_START;
        rx_ph = PH_START;
        tx_nbits = '0;
        rx_nbits = '0;
        tx_sreg = '0;
        rx_sreg = '0;
        io_last = '0;
        tx_line_q = 1'b1;
        tx_empty_q = 1'b1;
        ready_q = 1'b0;
        irq_pend_q = 1'b0;
        irq_rx_q = 1'b0;
        irq_tx_q = 1'b0;
        rx_fifo.delete();
    endfunction

    function automatic void raise_irq(input logic receive);
        irq_pend_q = 1'b1;
        irq_rx_q = receive;
        irq_tx_q = !receive;
    endfunction

    function automatic uart_status_t predict_uart_status(input in_item_t it);
        uart_status_t st;
        logic [3:0]   nbits;
        st = '0;
        nbits = m_eight ? CHAR_BITS_8 : CHAR_BITS_7;
        case (it.action)
            ACT_TICK:
            begin
                accum = accum + {1'b0, it.cycles};
                if (accum >= {1'b0, m_divisor})
                begin
                    accum = '0;
                    if (m_block)
                    begin
                        // transmitter steps before the receiver
                        if (!tx_empty_q && m_txen)
                        begin
                            case (tx_ph)
                                PH_START:
                                begin
                                    tx_line_q = 1'b0;
                                    tx_ph = PH_DATA;
                                end
                                PH_DATA:
                                begin
                                    tx_line_q = tx_sreg[0];
                                    tx_sreg = tx_sreg >> 1;
                                    tx_nbits = tx_nbits + 4'd1;
                                    if (tx_nbits >= nbits)
                                        tx_ph = PH_STOP;
                                end
                                PH_STOP:
                                begin
                                    tx_line_q = 1'b1;
                                    tx_ph = PH_EOF;
                                end
                                default:
                                begin
                                    tx_ph = PH_START;
                                    tx_nbits = '0;
                                    tx_empty_q = 1'b1;
                                    if (m_txirq)
                                        raise_irq(1'b0);
                                end
                            endcase
                        end
                        if (m_rxen)
                        begin
                            case (rx_ph)
                                PH_START:
                                begin
                                    if (!it.rx_level)
                                        rx_ph = PH_DATA;
                                end
                                PH_DATA:
                                begin
                                    if (rx_nbits < 4'd8)
                                        rx_sreg = rx_sreg | (8'(it.rx_level) << rx_nbits);
                                    rx_nbits = rx_nbits + 4'd1;
                                    if (rx_nbits >= nbits)
                                        rx_ph = PH_STOP;
                                end
                                PH_STOP:
                                begin
                                    st.stop_error = !it.rx_level;
                                    if (rx_fifo.size() >= RX_DEPTH)
                                        st.rx_overflow = 1'b1;
                                    else
                                        rx_fifo.push_back(rx_sreg);
                                    io_last = rx_sreg;
                                    ready_q = 1'b1;
                                    rx_ph = PH_START;
                                    rx_nbits = '0;
                                    rx_sreg = '0;
                                    if (m_rxirq)
                                        raise_irq(1'b1);
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            ACT_WRITE_TX:
            begin
                tx_sreg = it.tx_byte;
                tx_empty_q = 1'b0;
            end
            ACT_POP_RX:
            begin
                if (rx_fifo.size() != 0)
                begin
                    st.popped_byte = rx_fifo.pop_front();
                    st.popped_valid = 1'b1;
                end
            end
            ACT_CLR_READY:
                ready_q = 1'b0;
            ACT_CLR_IRQ:
            begin
                irq_pend_q = 1'b0;
                irq_rx_q = 1'b0;
                irq_tx_q = 1'b0;
            end
            default: ;
        endcase
        st.tx_level = tx_line_q;
        st.last_received = io_last;
        st.rx_ready = ready_q;
        st.tx_empty = tx_empty_q;
        st.irq_pending = irq_pend_q;
        st.irq_is_receive = irq_rx_q;
        st.irq_is_transmit = irq_tx_q;
        st.rx_count = 4'(rx_fifo.size());
        return st;
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [15:0] cyc,
                             input logic lvl, input logic [7:0] data);
        in_item_t    it;
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.action = act;
        it.cycles = cyc;
        it.rx_level = lvl;
        it.tx_byte = data;
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {7'd0, it.tx_byte, it.rx_level, it.cycles};
        do
            @(posedge clk);
        while (!s_tready);
        expected_status.push_back(predict_uart_status(it));
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BAUD_DIVISOR:  m_divisor = val;
            REG_EIGHT_BIT:     m_eight = val[0];
            REG_BLOCK_ENABLE:  m_block = val[0];
            REG_TX_ENABLE:     m_txen = val[0];
            REG_RX_ENABLE:     m_rxen = val[0];
            REG_RX_IRQ_ENABLE: m_rxirq = val[0];
            REG_TX_IRQ_ENABLE: m_txirq = val[0];
            default: ;
        endcase
    endtask

    // stop sending, wait for every result, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        settle();
        write_reg(REG_BAUD_DIVISOR, c.baud_divisor);
        write_reg(REG_EIGHT_BIT, {15'($urandom), c.eight_bit_chars});
        write_reg(REG_BLOCK_ENABLE, {15'($urandom), c.block_enable});
        write_reg(REG_TX_ENABLE, {15'($urandom), c.tx_enable});
        write_reg(REG_RX_ENABLE, {15'($urandom), c.rx_enable});
        write_reg(REG_RX_IRQ_ENABLE, {15'($urandom), c.rx_irq_enable});
        write_reg(REG_TX_IRQ_ENABLE, {15'($urandom), c.tx_irq_enable});
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned cycles_to_period();
        if (accum >= {1'b0, m_divisor})
            return 0;
        return m_divisor - accum;
    endfunction

    // tick that is sure to run one bit period
    task automatic bit_tick(input logic lvl);
        int unsigned need, cyc;
        need = cycles_to_period();
        if ($urandom_range(0, 7) == 0)
            cyc = $urandom_range(need, 65535);
        else
            cyc = need + $urandom_range(0, (65535 - need) < 3 ? 65535 - need : 3);
        send_item(ACT_TICK, cyc[15:0], lvl, 8'($urandom));
    endtask

    // activity that leaves the bit timing alone
    task automatic side_op();
        int unsigned r, need;
        r = $urandom_range(0, 99);
        need = cycles_to_period();
        if (r < pop_pct)
            send_item(ACT_POP_RX, 16'($urandom), 1'($urandom), 8'($urandom));
        else if (r < pop_pct + 25)
            send_item(ACT_WRITE_TX, 16'($urandom), 1'($urandom), 8'($urandom));
        else if (r < pop_pct + 40 && need > 1)
            send_item(ACT_TICK, 16'($urandom_range(0, need - 1)), 1'($urandom),
                      8'($urandom));
        else if (r < pop_pct + 55)
            send_item(ACT_CLR_READY, 16'($urandom), 1'($urandom), 8'($urandom));
        else if (r < pop_pct + 70)
            send_item(ACT_CLR_IRQ, 16'($urandom), 1'($urandom), 8'($urandom));
        else if (r < pop_pct + 78)
            send_item(3'($urandom_range(int'(ACT_CLR_IRQ) + 1, ACT_CODE_MAX)),
                      16'($urandom), 1'($urandom), 8'($urandom));
        else
            send_item(ACT_POP_RX, 16'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic rx_frame(input logic [7:0] data, input logic stop_lvl,
                            input int unsigned noise_pct);
        int unsigned nbits;
        // realign with the receiver before the start bit
        if (m_block && m_rxen)
            while (rx_ph != PH_START)
                bit_tick(1'b1);
        if (tx_empty_q && $urandom_range(0, 2) == 0)
            send_item(ACT_WRITE_TX, 16'($urandom), 1'($urandom), 8'($urandom));
        nbits = m_eight ? 8 : 7;
        bit_tick(1'b0);
        for (int i = 0; i < nbits; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                side_op();
            bit_tick(data[i]);
        end
        bit_tick(stop_lvl);
    endtask

    task automatic test_reset_defaults();
        for (int a = int'(ACT_CLR_IRQ) + 1; a <= ACT_CODE_MAX; a++)
            send_item(3'(a), 16'hFFFF, 1'b1, 8'hFF);
        send_item(ACT_POP_RX, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_TICK, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_TICK, 16'hFFFF, 1'b0, 8'h00);
        send_item(ACT_WRITE_TX, 16'h0000, 1'b0, 8'hA5);
        send_item(ACT_CLR_READY, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_CLR_IRQ, 16'h0000, 1'b0, 8'h00);
    endtask

    // zero divisor, stop bit low, write during a frame, irq type replaced
    task automatic test_directed_frame();
        cfg_t c;
        c = '{baud_divisor: 16'd0, eight_bit_chars: 1'b1, block_enable: 1'b1,
              tx_enable: 1'b1, rx_enable: 1'b1, rx_irq_enable: 1'b1,
              tx_irq_enable: 1'b1};
        apply_config(c);
        send_item(ACT_WRITE_TX, 16'h0000, 1'b0, 8'hFF);
        send_item(ACT_TICK, 16'hFFFF, 1'b0, 8'h00);
        for (int i = 0; i < 8; i++)
        begin
            if (i == 3)
                send_item(ACT_WRITE_TX, 16'hFFFF, 1'b1, 8'h00);
            send_item(ACT_TICK, 16'h0000, 1'b0, 8'h00);
        end
        send_item(ACT_TICK, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_TICK, 16'h0001, 1'b1, 8'h00);
        send_item(ACT_CLR_IRQ, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_POP_RX, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_POP_RX, 16'h0000, 1'b0, 8'h00);
        send_item(ACT_CLR_READY, 16'h0000, 1'b0, 8'h00);
    endtask

    task automatic test_rx_overflow();
        cfg_t c;
        c = '{baud_divisor: 16'd3, eight_bit_chars: 1'b0, block_enable: 1'b1,
              tx_enable: 1'b0, rx_enable: 1'b1, rx_irq_enable: 1'b1,
              tx_irq_enable: 1'b0};
        apply_config(c);
        pop_pct = 0;
        for (int i = 0; i < RX_DEPTH + 2; i++)
            rx_frame(8'($urandom), 1'b1, 0);
        for (int i = 0; i < RX_DEPTH + 1; i++)
            send_item(ACT_POP_RX, 16'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic test_random_phases();
        cfg_t        c;
        int unsigned ph, phase_end, r;
        ph = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (ph % 6)
                0: c.baud_divisor = 16'd0;
                1: c.baud_divisor = 16'd1;
                2: c.baud_divisor = 16'hFFFF;
                3: c.baud_divisor = 16'($urandom_range(2, 15));
                4: c.baud_divisor = 16'($urandom);
                default: c.baud_divisor = 16'($urandom_range(0, 4));
            endcase
            c.eight_bit_chars = 1'($urandom);
            c.block_enable = (ph % 7 != 5);
            c.tx_enable = ($urandom_range(0, 4) != 0);
            c.rx_enable = ($urandom_range(0, 5) != 0);
            c.rx_irq_enable = 1'($urandom);
            c.tx_irq_enable = 1'($urandom);
            no_idle = (ph % 4 == 3);
            case ($urandom_range(0, 2))
                0: pop_pct = 5;
                1: pop_pct = 20;
                default: pop_pct = 40;
            endcase
            apply_config(c);
            phase_end = items_sent + 90;
            while (items_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    rx_frame(8'($urandom), $urandom_range(0, 9) != 0, 25);
                else if (r < 82)
                    side_op();
                else
                    send_item(ACT_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
            end
            ph++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_frame();
        test_rx_overflow();
        test_random_phases();
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/btu_pkg.sv
rtl/btu_baud.sv
rtl/btu_tx.sv
rtl/btu_rx.sv
rtl/baud_tick_uart_transceiver_unit.sv
tb/baud_tick_uart_transceiver_unit_tb.sv
